FILE: design/dpwu_pkg.sv
// Shared types and codes for the device placement block.
`default_nettype none
package dpwu_pkg;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int POL_W   = 2;
    localparam int IDX_W   = 4;
    localparam int SIZE_W  = 48;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;
    localparam int MASK_W  = 16;
    localparam int USE_W   = 64;
    localparam int TURN_W  = 32;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 88;

    // Width for compares between counts and indexes (counts up to 31)
    localparam int CMP_W = 7;

    // Default device capacity
    localparam int MAX_DEVICES_DEF = 16;

    // Modulo unit: two quotient bits per cycle
    localparam int MOD_STEPS = TURN_W / 2;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_POLICY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NAMED  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    // Policies
    localparam logic [POL_W-1:0] POL_RR     = 2'd0;
    localparam logic [POL_W-1:0] POL_LEAST  = 2'd1;
    localparam logic [POL_W-1:0] POL_AFFIN  = 2'd2;
    localparam logic [POL_W-1:0] POL_MIRROR = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_DEV  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_SZ = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_IDX = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch an accepted item
        logic prep;       // set up the modulo unit and the scan
        logic mod_step;   // one modulo iteration
        logic scan_step;  // compare one device in the least used scan
        logic commit;     // update state and load the output register
    } dpwu_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_mod;
        logic need_scan;
        logic mod_last;
        logic scan_done;
        logic out_free;
    } dpwu_sts_t;

endpackage
`default_nettype wire

FILE: design/dpwu_ctrl.sv
// Controller state machine for the device placement block.
`default_nettype none
module dpwu_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    output logic                    ready,
    input  wire dpwu_pkg::dpwu_sts_t sts,
    output dpwu_pkg::dpwu_cmd_t     cmd
);
    import dpwu_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_MOD    = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_UPDATE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.load      = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.prep = 1'b1;
                priority if (sts.need_mod)
                    state_next = ST_MOD;
                else if (sts.need_scan)
                    state_next = ST_SCAN;
                else
                    state_next = ST_UPDATE;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = ST_UPDATE;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // An accepted item always takes the controller out of idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !ready)
        else $error("controller stayed ready after accepting an item");

    // The modulo loop keeps running until its last step
    a_mod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD && !sts.mod_last) |=> (state_reg == ST_MOD))
        else $error("modulo loop left early");

endmodule
`default_nettype wire

FILE: design/dpwu_datapath.sv
// Datapath: usage table, modulo unit, least used scan and output register.
`default_nettype none
module dpwu_datapath #(
    parameter int MAX_DEVICES = dpwu_pkg::MAX_DEVICES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dpwu_pkg::CNT_W-1:0]    cfg_wr_data,
    input  wire logic [dpwu_pkg::S_DATA_W-1:0] s_tdata,
    input  wire dpwu_pkg::dpwu_cmd_t           cmd,
    output dpwu_pkg::dpwu_sts_t                sts,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dpwu_pkg::M_DATA_W-1:0]      m_tdata
);
    import dpwu_pkg::*;

    localparam int NW = $clog2(MAX_DEVICES + 1);
    localparam int DW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int RW = NW + 1;

    // Configuration and request registers
    logic [CNT_W-1:0]  dev_count_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [POL_W-1:0]  pol_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SIZE_W-1:0] size_reg;

    // Persistent state
    logic [USE_W-1:0]  usage_reg [MAX_DEVICES];
    logic [TURN_W-1:0] turn_reg;
    logic [DW-1:0]     last_reg;

    // Modulo unit
    logic [RW-1:0]        rem_reg;
    logic [TURN_W-1:0]    div_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;

    // Least used scan
    logic [NW-1:0]     scan_idx_reg;
    logic [USE_W-1:0]  best_reg;
    logic [DW-1:0]     best_idx_reg;

    // Output register
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [NW-1:0]     n;
    logic              n_zero;
    logic              size_zero;
    logic              idx_ok;
    logic              last_ok;
    logic [RW-1:0]     t1, r1, t2, r2, nx;
    logic [DW-1:0]     target;
    logic [DW-1:0]     rd_addr;
    logic [USE_W-1:0]  rd_data;
    logic [USE_W:0]    sum;
    logic [USE_W-1:0]  add_val;
    logic [USE_W-1:0]  sub_val;
    logic [USE_W-1:0]  new_val;
    logic              wr_en;
    logic              place_ok;
    logic [STAT_W-1:0] res_stat;
    logic [IDX_W-1:0]  res_dev;
    logic [MASK_W-1:0] res_mask;
    logic [MASK_W-1:0] mirror;
    logic [USE_W-1:0]  res_use;

    // Present device count, clamped to capacity
    always_comb
    begin
        if (CMP_W'(dev_count_reg) > CMP_W'(MAX_DEVICES))
            n = NW'(MAX_DEVICES);
        else
            n = NW'(dev_count_reg);
    end

    assign n_zero    = (n == '0);
    assign size_zero = (size_reg == '0);
    assign idx_ok    = CMP_W'(idx_reg) < CMP_W'(n);
    assign last_ok   = CMP_W'(last_reg) < CMP_W'(n);

    // Status toward the controller
    assign sts.need_mod  = (req_reg == REQ_POLICY) && !n_zero && !size_zero
                           && (pol_reg == POL_RR);
    assign sts.need_scan = (req_reg == REQ_POLICY) && !n_zero && !size_zero
                           && (pol_reg == POL_LEAST);
    assign sts.mod_last  = (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1));
    assign sts.scan_done = (CMP_W'(scan_idx_reg) >= CMP_W'(n));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Two restoring division steps per cycle; only the remainder is kept
    assign nx = RW'(n);
    always_comb
    begin
        t1 = {rem_reg[RW-2:0], div_reg[TURN_W-1]};
        r1 = (t1 >= nx) ? (t1 - nx) : t1;
        t2 = {r1[RW-2:0], div_reg[TURN_W-2]};
        r2 = (t2 >= nx) ? (t2 - nx) : t2;
    end

    // Device chosen for this item
    always_comb
    begin
        target = '0;
        if (req_reg == REQ_POLICY)
        begin
            unique case (pol_reg)
                POL_RR:     target = DW'(rem_reg);
                POL_LEAST:  target = best_idx_reg;
                POL_AFFIN:  target = last_ok ? last_reg : '0;
                POL_MIRROR: target = '0;
                default:    target = '0;
            endcase
        end
        else
        begin
            target = DW'(idx_reg);
        end
    end

    // Read port on the usage table, shared by the scan and the update
    assign rd_addr = cmd.scan_step ? scan_idx_reg[DW-1:0] : target;
    assign rd_data = usage_reg[rd_addr];

    // Saturating add and floored subtract
    assign sum     = {1'b0, rd_data} + (USE_W + 1)'(size_reg);
    assign add_val = sum[USE_W] ? {USE_W{1'b1}} : sum[USE_W-1:0];
    assign sub_val = (rd_data >= USE_W'(size_reg)) ? (rd_data - USE_W'(size_reg)) : '0;

    // Mirror mask: one bit per present device
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            mirror[i] = CMP_W'(i) < CMP_W'(n);
        end
    end

    // Result and write decision
    always_comb
    begin
        res_stat = STAT_OK;
        res_dev  = '0;
        res_mask = '0;
        res_use  = '0;
        new_val  = add_val;
        wr_en    = 1'b0;
        place_ok = 1'b0;
        unique case (req_reg)
            REQ_POLICY:
            begin
                priority if (n_zero)
                    res_stat = STAT_NO_DEV;
                else if (size_zero)
                    res_stat = STAT_ZERO_SZ;
                else
                begin
                    place_ok = 1'b1;
                    wr_en    = 1'b1;
                    res_dev  = IDX_W'(target);
                    res_mask = (pol_reg == POL_MIRROR) ? mirror : '0;
                    res_use  = add_val;
                end
            end
            REQ_NAMED:
            begin
                priority if (!idx_ok)
                    res_stat = STAT_BAD_IDX;
                else if (size_zero)
                    res_stat = STAT_ZERO_SZ;
                else
                begin
                    place_ok = 1'b1;
                    wr_en    = 1'b1;
                    res_dev  = idx_reg;
                    res_use  = add_val;
                end
            end
            REQ_FREE:
            begin
                res_dev = idx_reg;
                new_val = sub_val;
                if (idx_ok)
                begin
                    wr_en   = 1'b1;
                    res_use = sub_val;
                end
            end
            REQ_NONE:
            begin
                res_stat = STAT_OK;
            end
            default:
            begin
                res_stat = STAT_OK;
            end
        endcase
    end

    // Control state: config, usage table, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_count_reg <= '0;
            turn_reg      <= '0;
            last_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            mod_cnt_reg   <= '0;
            scan_idx_reg  <= '0;
            for (int i = 0; i < MAX_DEVICES; i++)
            begin
                usage_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                dev_count_reg <= cfg_wr_data;
            if (cmd.prep)
            begin
                mod_cnt_reg  <= '0;
                scan_idx_reg <= NW'(1);
            end
            if (cmd.mod_step)
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            if (cmd.scan_step)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cmd.commit)
            begin
                if (wr_en)
                    usage_reg[target] <= new_val;
                if (place_ok)
                    last_reg <= target;
                if (place_ok && (req_reg == REQ_POLICY) && (pol_reg == POL_RR))
                    turn_reg <= turn_reg + 1'b1;
            end
            if (cmd.commit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers: request fields, modulo unit, scan best and result data
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= s_tdata[1:0];
            pol_reg  <= s_tdata[3:2];
            idx_reg  <= s_tdata[7:4];
            size_reg <= s_tdata[55:8];
        end
        if (cmd.prep)
        begin
            rem_reg      <= '0;
            div_reg      <= turn_reg;
            best_reg     <= usage_reg[0];
            best_idx_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg <= r2;
            div_reg <= {div_reg[TURN_W-3:0], 2'b00};
        end
        if (cmd.scan_step && (rd_data < best_reg))
        begin
            best_reg     <= rd_data;
            best_idx_reg <= scan_idx_reg[DW-1:0];
        end
        if (cmd.commit)
            m_tdata_reg <= {2'b00, res_use, res_mask, res_dev, res_stat};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // Every commit shows up as a valid result next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid_reg)
        else $error("commit did not produce a result");

endmodule
`default_nettype wire

FILE: design/device_placement_with_usage_top.sv
// Top level of the device placement block with per-device usage tracking.
//
// Tracks bytes in use on up to MAX_DEVICES devices and answers one result item
// per request item: placement by policy (round robin, least used, affinity,
// mirror), placement on a named device, or a free. The user must write the device
// count through cfg_wr_en/cfg_wr_data only while no item is in flight; the block
// itself does not enforce this. One item is worked at a time; s_tready is high only
// while the block is idle, and a finished result waits in an output register so
// the next item can already be taken. Round robin computes the turn counter
// modulo the device count two bits per cycle, least used compares one present
// device per cycle against the least found so far, and all other items go
// straight to the update, which waits while the output register is still full.
`default_nettype none
module device_placement_with_usage_top #(
    parameter int MAX_DEVICES = dpwu_pkg::MAX_DEVICES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Device count register
    input  wire logic                          cfg_wr_en,
    input  wire logic [dpwu_pkg::CNT_W-1:0]    cfg_wr_data,
    // Request items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // req_type[1:0], policy[3:2], device_index[7:4], request_size[55:8]
    input  wire logic [dpwu_pkg::S_DATA_W-1:0] s_tdata,
    // Result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[1:0], chosen_device[5:2], mirror_mask[21:6], usage_after[85:22]
    output logic [dpwu_pkg::M_DATA_W-1:0]      m_tdata
);
    import dpwu_pkg::*;

    dpwu_cmd_t cmd;
    dpwu_sts_t sts;
    logic      accept;

    assign accept = s_tvalid && s_tready;

    // Sequencer
    dpwu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ready  (s_tready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // Usage table and arithmetic
    dpwu_datapath #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

FILE: bench/dpwu_checker.sv
// Checker for the device placement block: watches both streams, predicts and compares results.
module dpwu_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dpwu_pkg::CNT_W-1:0]    cfg_wr_data,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [dpwu_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [dpwu_pkg::M_DATA_W-1:0] m_tdata,
    output int                                 fail_count,
    output int                                 pending
);
    import dpwu_pkg::*;

    localparam int NUM_DEV     = MAX_DEVICES_DEF;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  dev;
        logic [MASK_W-1:0] mask;
        logic [USE_W-1:0]  usage;
    } placement_t;

    // Predicted results, oldest first
    placement_t placement_q[$];
    placement_t oldest;

    // Shadow copy of the block's state
    logic [USE_W-1:0]  usage_tbl [NUM_DEV];
    logic [TURN_W-1:0] turn_ctr;
    logic [IDX_W-1:0]  last_dev;
    logic [CNT_W-1:0]  dev_count;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [USE_W-1:0] add_clamped(input logic [USE_W-1:0] a,
                                                     input logic [SIZE_W-1:0] b);
        logic [USE_W:0] sum;
        sum = {1'b0, a} + {{(USE_W+1-SIZE_W){1'b0}}, b};
        return sum[USE_W] ? {USE_W{1'b1}} : sum[USE_W-1:0];
    endfunction

    // Apply one request item to the shadow state and return its result
    function automatic placement_t place_request(input logic [S_DATA_W-1:0] word);
        logic [REQ_W-1:0]  kind;
        logic [POL_W-1:0]  pol;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] sz;
        logic [IDX_W-1:0]  tgt;
        logic [USE_W-1:0]  best;
        int unsigned       n;
        placement_t        r;
        kind = word[1:0];
        pol  = word[3:2];
        idx  = word[7:4];
        sz   = word[55:8];
        n    = (dev_count > NUM_DEV) ? NUM_DEV : dev_count;
        r    = '0;
        tgt  = '0;
        case (kind)
            REQ_POLICY:
            begin
                if (n == 0)
                    r.status = STAT_NO_DEV;
                else if (sz == 0)
                    r.status = STAT_ZERO_SZ;
                else
                begin
                    case (pol)
                        POL_RR:
                        begin
                            tgt      = IDX_W'(turn_ctr % n);
                            turn_ctr = turn_ctr + 1'b1;
                        end
                        POL_LEAST:
                        begin
                            // lowest index wins a tie
                            best = usage_tbl[0];
                            for (int i = 1; i < n; i++)
                            begin
                                if (usage_tbl[i] < best)
                                begin
                                    best = usage_tbl[i];
                                    tgt  = IDX_W'(i);
                                end
                            end
                        end
                        POL_AFFIN:
                            tgt = (last_dev < n) ? last_dev : '0;
                        default:
                        begin
                            for (int i = 0; i < n; i++)
                                r.mask[i] = 1'b1;
                        end
                    endcase
                    last_dev       = tgt;
                    usage_tbl[tgt] = add_clamped(usage_tbl[tgt], sz);
                    r.dev          = tgt;
                    r.usage        = usage_tbl[tgt];
                end
            end
            REQ_NAMED:
            begin
                if (idx >= n)
                    r.status = STAT_BAD_IDX;
                else if (sz == 0)
                    r.status = STAT_ZERO_SZ;
                else
                begin
                    last_dev       = idx;
                    usage_tbl[idx] = add_clamped(usage_tbl[idx], sz);
                    r.dev          = idx;
                    r.usage        = usage_tbl[idx];
                end
            end
            REQ_FREE:
            begin
                // always ok; out-of-range index reports zero usage
                r.status = STAT_OK;
                r.dev    = idx;
                if (idx < n)
                begin
                    if (usage_tbl[idx] >= sz)
                        usage_tbl[idx] = usage_tbl[idx] - sz;
                    else
                        usage_tbl[idx] = '0;
                    r.usage = usage_tbl[idx];
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [USE_W-1:0] want,
                               input logic [USE_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s expected 0x%0h got 0x%0h", name, want, got);
        end
    endtask

    // Results first, then register writes, then new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            placement_q.delete();
            for (int i = 0; i < NUM_DEV; i++)
                usage_tbl[i] = '0;
            turn_ctr  = '0;
            last_dev  = '0;
            dev_count = '0;
            pending   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (placement_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("result item 0x%0h with no request waiting", m_tdata);
                end
                else
                begin
                    oldest = placement_q.pop_front();
                    check_field("status", oldest.status, m_tdata[1:0]);
                    check_field("chosen_device", oldest.dev, m_tdata[5:2]);
                    check_field("mirror_mask", oldest.mask, m_tdata[21:6]);
                    check_field("usage_after", oldest.usage, m_tdata[85:22]);
                end
            end
            if (cfg_wr_en)
                dev_count = cfg_wr_data;
            if (s_tvalid && s_tready)
                placement_q.insert(placement_q.size(), place_request(s_tdata));
            pending = placement_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the device placement block: clock, reset, stimulus and verdict.
module tb_top;
    import dpwu_pkg::*;

    localparam int  NUM_DEV      = MAX_DEVICES_DEF;
    localparam int  PHASE_ITEMS  = 180;
    localparam int  RX_HOLD      = 300;
    // a short run of max-size additions on one device
    localparam int  CLAMP_ITEMS  = 24;
    localparam int  LIMIT_CYCLES = 5000000;
    localparam logic [SIZE_W-1:0] SIZE_ALL = {SIZE_W{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CNT_W-1:0]    cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    int                  fail_count;
    int                  pending;

    // Receiver control, shared with the ready process
    bit rx_random;
    bit rx_hold_req;
    int stall_left;

    logic [CNT_W-1:0] cur_count;
    int               phase_counts [10] = '{16, 5, 1, 31, 0, 9, 2, 16, 13, 17};
    bit               quiet_tx;

    device_placement_with_usage_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    dpwu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("device_placement_with_usage_top verification failed");
        $finish;
    end

    // Result side ready: random stalls, plus one long hold on request
    initial
    begin
        int r;
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall_left  = RX_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!rx_random)
                m_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
                end
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_word(input logic [S_DATA_W-1:0] word);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [POL_W-1:0] pol,
                            input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] sz);
        send_word({sz, idx, pol, kind});
    endtask

    // Drop valid between items, with random data on the bus; n sets the gap
    task automatic sender_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'({$urandom, $urandom});
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every result is back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_count = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random request, biased toward indexes of present devices
    function automatic logic [S_DATA_W-1:0] rand_word(input int unsigned n);
        logic [REQ_W-1:0]  kind;
        logic [POL_W-1:0]  pol;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] sz;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 45)
            kind = REQ_POLICY;
        else if (r < 70)
            kind = REQ_NAMED;
        else if (r < 95)
            kind = REQ_FREE;
        else
            kind = REQ_NONE;
        pol = POL_W'($urandom_range(0, 3));
        if (n > 0 && $urandom_range(0, 3) != 0)
            idx = IDX_W'($urandom_range(0, n - 1));
        else
            idx = IDX_W'($urandom_range(0, NUM_DEV - 1));
        r = $urandom_range(0, 99);
        if (r < 5)
            sz = '0;
        else if (r < 10)
            sz = SIZE_ALL;
        else if (r < 45)
            sz = SIZE_W'($urandom_range(1, 4096));
        else
            sz = SIZE_W'({$urandom, $urandom});
        return {sz, idx, pol, kind};
    endfunction

    // Stimulus and verdict
    initial
    begin
        int unsigned eff;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rx_random   = 1'b0;
        rx_hold_req = 1'b0;
        quiet_tx    = 1'b0;
        cur_count   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // No devices present: no-device and bad-index errors, a free and a none
        send_req(REQ_POLICY, POL_RR, 4'd0, 48'd5);
        send_req(REQ_POLICY, POL_LEAST, 4'd0, 48'd0);
        send_req(REQ_NAMED, POL_RR, 4'd0, 48'd0);
        send_req(REQ_FREE, POL_RR, 4'd3, 48'd7);
        send_req(REQ_NONE, POL_MIRROR, 4'd15, SIZE_ALL);

        // Full set: each policy, zero size, free floor, max fields
        set_count(5'd16);
        send_req(REQ_NAMED, POL_MIRROR, 4'd15, SIZE_ALL);
        send_req(REQ_NAMED, POL_RR, 4'd0, 48'd0);
        send_req(REQ_POLICY, POL_MIRROR, 4'd0, 48'd0);
        send_req(REQ_POLICY, POL_RR, 4'd0, 48'd100);
        send_req(REQ_POLICY, POL_RR, 4'd0, 48'd200);
        send_req(REQ_POLICY, POL_LEAST, 4'd0, 48'd1);
        send_req(REQ_POLICY, POL_AFFIN, 4'd0, 48'd9);
        send_req(REQ_POLICY, POL_MIRROR, 4'd0, 48'd1);
        send_req(REQ_FREE, POL_RR, 4'd15, SIZE_ALL);
        send_req(REQ_FREE, POL_RR, 4'd0, 48'd1000);
        send_req(REQ_FREE, POL_RR, 4'd1, 48'd0);
        send_req(REQ_NAMED, POL_RR, 4'd12, 48'd3);

        // Small set: affinity falls back to device 0, index out of range
        set_count(5'd3);
        send_req(REQ_POLICY, POL_AFFIN, 4'd0, 48'd4);
        send_req(REQ_NAMED, POL_RR, 4'd3, 48'd1);
        send_req(REQ_FREE, POL_RR, 4'd5, 48'd1);
        send_req(REQ_POLICY, POL_RR, 4'd0, 48'd1);

        // Count above capacity, then a single device
        set_count(5'd31);
        send_req(REQ_POLICY, POL_MIRROR, 4'd0, 48'd2);
        set_count(5'd1);
        send_req(REQ_POLICY, POL_LEAST, 4'd0, 48'd1);
        send_req(REQ_POLICY, POL_RR, 4'd0, 48'd1);
        send_req(REQ_POLICY, POL_MIRROR, 4'd0, 48'd1);

        // Random phases over a spread of device counts
        foreach (phase_counts[p])
        begin
            set_count(CNT_W'(phase_counts[p]));
            eff       = (cur_count > NUM_DEV) ? NUM_DEV : cur_count;
            rx_random = (p % 3 != 2);
            quiet_tx  = (p % 3 == 2);
            if (p == 1)
            begin
                // long receiver hold while items keep coming
                rx_hold_req = 1'b1;
                repeat (12) send_word(rand_word(eff));
                settle();
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_word(rand_word(eff));
                if (!quiet_tx)
                    sender_gap(gap_len());
                if ($urandom_range(0, 59) == 0)
                    settle();
            end
        end

        // Pile max-size placements on one device, then free and rebalance
        set_count(5'd16);
        rx_random = 1'b0;
        for (int k = 0; k < CLAMP_ITEMS; k++)
            send_req(REQ_NAMED, POL_RR, 4'd15, SIZE_ALL);
        send_req(REQ_FREE, POL_RR, 4'd15, 48'd1);
        send_req(REQ_NAMED, POL_RR, 4'd15, 48'd5);
        send_req(REQ_POLICY, POL_LEAST, 4'd0, 48'd1);
        send_req(REQ_POLICY, POL_AFFIN, 4'd0, 48'd1);

        settle();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("device_placement_with_usage_top verification clean");
        else
            $display("device_placement_with_usage_top verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/dpwu_pkg.sv
design/dpwu_ctrl.sv
design/dpwu_datapath.sv
design/device_placement_with_usage_top.sv
bench/dpwu_checker.sv
bench/tb_top.sv
